[rtl/sas_pkg.sv]
package sas_pkg;

  localparam int SLOTS     = 14;
  localparam int LOG_DEPTH = 14;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int LOG_W     = $clog2(LOG_DEPTH);
  localparam int LCNT_W    = $clog2(LOG_DEPTH + 1);
  localparam int MIN_W     = 11;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_ADD       = 3'd1;
  localparam logic [2:0] OP_CLR_SCHED = 3'd2;
  localparam logic [2:0] OP_CLR_LOG   = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [MIN_W-1:0]  wdata;
    logic [SLOT_W-1:0] raddr;
    logic [MIN_W-1:0]  key;
  } tbl_ctl_t;

endpackage

[rtl/sas_table.sv]
module sas_table (
  input  logic             clk,
  input  sas_pkg::tbl_ctl_t ctl,
  output logic             hit
);
  import sas_pkg::*;

  logic [MIN_W-1:0] mem [SLOTS];
  logic [MIN_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    rdata <= mem[ctl.raddr];
  end

  // shared comparator: tick match and duplicate search
  assign hit = (rdata == ctl.key);

endmodule

[rtl/sequential_alarm_schedule_unit.sv]
// Steps: an accepted item passes the fetch state, then, for a checked add, a scan that reads
// one entry a cycle over the N table entries, then the exec state that registers its result.
// A new item is accepted only once the previous item's result is registered;
// the last step holds while an earlier result waits on m_axis_tready.
// Reset (rst, synchronous): empties table and fired list, last fired slot -1;
// the table and fired list contents are not cleared.
module sequential_alarm_schedule_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [10:0] time_minute, [11] check_duplicate, [15:12] read_index
  input  logic [15:0] s_axis_tdata,
  // [2:0] opcode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] dispense, [4:1] fired_slot, [9:5] last_fired_slot, [13:10] fired_count,
  // [18:14] read_slot, [19] add_accepted, [23:20] entry_count
  output logic [23:0] m_axis_tdata
);
  import sas_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0]        state;
  logic [2:0]        op_r;
  logic [MIN_W-1:0]  t_r;
  logic              dup_r;
  logic [3:0]        ridx_r;

  logic [CNT_W-1:0]  count, count_next;
  logic [SLOT_W-1:0] next_slot, next_slot_next;
  logic signed [4:0] last_slot, last_slot_next;
  logic [LCNT_W-1:0] log_count, log_count_next;
  logic [MIN_W-1:0]  last_min, last_min_next;
  logic              have_fired, have_fired_next;

  logic [CNT_W-1:0]  scan_idx;
  logic              cmp_pend;
  logic              found;

  logic              m_valid;
  logic [23:0]       out_data;

  logic [3:0]        log_mem [LOG_DEPTH];
  logic [3:0]        log_rdata;
  logic              log_we;

  tbl_ctl_t          tbl;
  logic              hit;

  logic              exec_go;
  logic              fire;
  logic [CNT_W-1:0]  ns_inc;
  logic              o_disp;
  logic [3:0]        o_fslot;
  logic signed [4:0] o_rslot;
  logic              o_acc;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = out_data;
  assign exec_go       = (state == S_EXEC) && (!m_valid || m_axis_tready);

  assign fire = (op_r == OP_TICK) && (count != '0) && (CNT_W'(next_slot) < count) &&
                !(have_fired && (t_r == last_min)) && hit;
  assign ns_inc = CNT_W'(next_slot) + CNT_W'(1);

  always_comb begin
    tbl.we    = exec_go && (op_r == OP_ADD) && (count < CNT_W'(SLOTS)) && !found;
    tbl.waddr = count[SLOT_W-1:0];
    tbl.wdata = t_r;
    tbl.raddr = (state == S_SCAN) ? scan_idx[SLOT_W-1:0] : next_slot;
    tbl.key   = t_r;
  end

  sas_table u_table (
    .clk (clk),
    .ctl (tbl),
    .hit (hit)
  );

  assign log_we = exec_go && fire && (log_count < LCNT_W'(LOG_DEPTH));

  always_ff @(posedge clk) begin
    if (log_we) begin
      log_mem[log_count[LOG_W-1:0]] <= 4'(next_slot);
    end
    log_rdata <= log_mem[ridx_r[LOG_W-1:0]];
  end

  always_comb begin
    count_next      = count;
    next_slot_next  = next_slot;
    last_slot_next  = last_slot;
    log_count_next  = log_count;
    last_min_next   = last_min;
    have_fired_next = have_fired;
    o_disp          = 1'b0;
    o_fslot         = '0;
    o_rslot         = -5'sd1;
    o_acc           = 1'b0;
    case (op_r)
      OP_TICK: begin
        if (fire) begin
          o_disp          = 1'b1;
          o_fslot         = 4'(next_slot);
          last_slot_next  = $signed({1'b0, 4'(next_slot)});
          if (log_count < LCNT_W'(LOG_DEPTH)) begin
            log_count_next = log_count + LCNT_W'(1);
          end
          last_min_next   = t_r;
          have_fired_next = 1'b1;
          next_slot_next  = (ns_inc >= count) ? '0 : ns_inc[SLOT_W-1:0];
        end
      end
      OP_ADD: begin
        if ((count < CNT_W'(SLOTS)) && !found) begin
          count_next = count + CNT_W'(1);
          o_acc      = 1'b1;
        end
      end
      OP_CLR_SCHED: begin
        count_next      = '0;
        next_slot_next  = '0;
        last_slot_next  = -5'sd1;
        log_count_next  = '0;
        have_fired_next = 1'b0;
        last_min_next   = '0;
      end
      OP_CLR_LOG: begin
        log_count_next = '0;
      end
      OP_READ: begin
        if (LCNT_W'(ridx_r) < log_count) begin
          o_rslot = $signed({1'b0, log_rdata});
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      next_slot  <= '0;
      last_slot  <= -5'sd1;
      log_count  <= '0;
      last_min   <= '0;
      have_fired <= 1'b0;
      scan_idx   <= '0;
      cmp_pend   <= 1'b0;
      found      <= 1'b0;
      m_valid    <= 1'b0;
    end else begin
      if (m_valid && m_axis_tready && !exec_go) begin
        m_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_r     <= s_axis_tuser;
            t_r      <= s_axis_tdata[10:0];
            dup_r    <= s_axis_tdata[11];
            ridx_r   <= s_axis_tdata[15:12];
            scan_idx <= '0;
            cmp_pend <= 1'b0;
            found    <= 1'b0;
            state    <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= ((op_r == OP_ADD) && dup_r) ? S_SCAN : S_EXEC;
        end
        S_SCAN: begin
          if (cmp_pend && hit) begin
            found <= 1'b1;
          end
          if (scan_idx < count) begin
            scan_idx <= scan_idx + CNT_W'(1);
            cmp_pend <= 1'b1;
          end else begin
            cmp_pend <= 1'b0;
            if (!cmp_pend) begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            count      <= count_next;
            next_slot  <= next_slot_next;
            last_slot  <= last_slot_next;
            log_count  <= log_count_next;
            last_min   <= last_min_next;
            have_fired <= have_fired_next;
            m_valid    <= 1'b1;
            out_data   <= {4'(count_next), o_acc, o_rslot, 4'(log_count_next),
                           last_slot_next, o_fslot, o_disp};
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= CNT_W'(SLOTS)) && (log_count <= LCNT_W'(LOG_DEPTH)))
    else $error("entry or log count beyond capacity");

  a_ptr_in_table: assert property (@(posedge clk) disable iff (rst)
    ((count == '0) && (next_slot == '0)) || (CNT_W'(next_slot) < count))
    else $error("next slot outside the table");

  a_fire_matches_last: assert property (@(posedge clk) disable iff (rst)
    exec_go && fire |=> (last_slot == $signed({1'b0, out_data[4:1]})) && out_data[0])
    else $error("fired slot and last fired slot disagree");

  a_no_exec_while_stalled: assert property (@(posedge clk) disable iff (rst)
    m_valid && !m_axis_tready && (state == S_EXEC) |=> (state == S_EXEC) && $stable(count))
    else $error("state updated while result was stalled");
`endif

endmodule

[bench/sas_status_checker.sv]
module sas_status_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sas_pkg::*;

  typedef struct packed {
    logic [3:0]        entries;
    logic              accepted;
    logic signed [4:0] read_slot;
    logic [3:0]        log_cnt;
    logic signed [4:0] last_slot;
    logic [3:0]        fired_slot;
    logic              dispense;
  } status_t;

  logic [MIN_W-1:0]  alarm_min [SLOTS];
  logic [CNT_W-1:0]  alarm_cnt;
  logic [SLOT_W-1:0] next_ptr;
  logic signed [4:0] last_fired;
  logic [LOG_W-1:0]  fire_log [LOG_DEPTH];
  logic [LCNT_W-1:0] log_cnt;
  logic [MIN_W-1:0]  last_min;
  logic              fired_flag;

  status_t expected_status [$];

  function automatic status_t schedule_step(logic [2:0] op, logic [MIN_W-1:0] minute,
                                            logic dup, logic [3:0] ridx);
    status_t r;
    logic    found;
    r = '0;
    r.read_slot = -5'sd1;
    found = 1'b0;
    case (op)
      OP_TICK: begin
        if (alarm_cnt != 0 && next_ptr < alarm_cnt && !(fired_flag && minute == last_min) &&
            alarm_min[next_ptr] == minute) begin
          r.dispense   = 1'b1;
          r.fired_slot = next_ptr;
          last_fired   = {1'b0, next_ptr};
          if (log_cnt < LOG_DEPTH) begin
            fire_log[log_cnt] = next_ptr;
            log_cnt = log_cnt + 1'b1;
          end
          last_min   = minute;
          fired_flag = 1'b1;
          if (next_ptr + 1 >= alarm_cnt) next_ptr = '0;
          else next_ptr = next_ptr + 1'b1;
        end
      end
      OP_ADD: begin
        for (int i = 0; i < alarm_cnt; i++) begin
          if (alarm_min[i] == minute) found = 1'b1;
        end
        if (alarm_cnt < SLOTS && !(dup && found)) begin
          alarm_min[alarm_cnt] = minute;
          alarm_cnt  = alarm_cnt + 1'b1;
          r.accepted = 1'b1;
        end
      end
      OP_CLR_SCHED: begin
        alarm_cnt  = '0;
        next_ptr   = '0;
        last_fired = -5'sd1;
        log_cnt    = '0;
        fired_flag = 1'b0;
        last_min   = '0;
      end
      OP_CLR_LOG: log_cnt = '0;
      OP_READ: begin
        if (ridx < log_cnt) r.read_slot = {1'b0, fire_log[ridx]};
      end
      default: ;
    endcase
    r.last_slot = last_fired;
    r.log_cnt   = log_cnt;
    r.entries   = alarm_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      fails++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    status_t exp_r;
    status_t got_r;
    if (rst) begin
      fails      = 0;
      alarm_cnt  = '0;
      next_ptr   = '0;
      last_fired = -5'sd1;
      log_cnt    = '0;
      last_min   = '0;
      fired_flag = 1'b0;
      expected_status.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_status.push_back(schedule_step(s_axis_tuser, s_axis_tdata[10:0],
                                                s_axis_tdata[11], s_axis_tdata[15:12]));
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = m_axis_tdata;
        if (expected_status.size() == 0) begin
          fails++;
          $display("%0t: result with no item pending, expected none got %h", $time,
                   m_axis_tdata);
        end else begin
          exp_r = expected_status.pop_front();
          check_field("dispense", exp_r.dispense, got_r.dispense);
          check_field("fired_slot", exp_r.fired_slot, got_r.fired_slot);
          check_field("last_fired_slot", exp_r.last_slot, got_r.last_slot);
          check_field("fired_count", exp_r.log_cnt, got_r.log_cnt);
          check_field("read_slot", exp_r.read_slot, got_r.read_slot);
          check_field("add_accepted", exp_r.accepted, got_r.accepted);
          check_field("entry_count", exp_r.entries, got_r.entries);
        end
      end
    end
    pending <= expected_status.size();
  end

endmodule

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sas_pkg::*;

  localparam logic [2:0] OP_NOP5 = 3'd5;
  localparam logic [2:0] OP_NOP6 = 3'd6;
  localparam logic [2:0] OP_NOP7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  int fails;
  int pending;
  int src_idle = 0;
  int sink_stall = 0;
  int sent = 0;

  sequential_alarm_schedule_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sas_status_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fails         (fails),
    .pending       (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall);
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic send(logic [2:0] op, logic [10:0] minute, logic dup, logic [3:0] ridx);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {ridx, dup, minute};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  function automatic logic [10:0] rand_minute();
    if ($urandom_range(9) == 0) return 11'($urandom_range(2047, 1440));
    return 11'($urandom_range(1439));
  endfunction

  function automatic logic [2:0] rand_spare_op();
    case ($urandom_range(2))
      0: return OP_NOP5;
      1: return OP_NOP6;
      default: return OP_NOP7;
    endcase
  endfunction

  task automatic noise_item();
    logic [2:0] op;
    case ($urandom_range(5))
      0: op = OP_TICK;
      1: op = OP_ADD;
      2: op = OP_CLR_LOG;
      3: op = OP_READ;
      4: op = rand_spare_op();
      default: op = ($urandom_range(3) == 0) ? OP_CLR_SCHED : OP_TICK;
    endcase
    send(op, 11'($urandom_range(2047)), 1'($urandom_range(1)), 4'($urandom_range(15)));
  endtask

  task automatic schedule_run();
    logic [10:0] plan [16];
    logic [10:0] prev;
    int          k;
    int          p;
    int          n_ticks;
    int          r;
    send(OP_CLR_SCHED, rand_minute(), 1'($urandom_range(1)), 4'($urandom_range(15)));
    k = ($urandom_range(4) == 0) ? $urandom_range(16, 12) : $urandom_range(8, 1);
    for (int i = 0; i < k; i++) begin
      if (i > 0 && $urandom_range(4) == 0) plan[i] = plan[$urandom_range(i - 1)];
      else plan[i] = rand_minute();
      send(OP_ADD, plan[i], 1'($urandom_range(1)), 4'($urandom_range(15)));
    end
    if (k > SLOTS) k = SLOTS;
    p = 0;
    prev = plan[0];
    n_ticks = $urandom_range(40, 5);
    for (int i = 0; i < n_ticks; i++) begin
      r = $urandom_range(99);
      if (r < 65) begin
        prev = plan[p];
        p = (p + 1) % k;
        send(OP_TICK, prev, 1'($urandom_range(1)), 4'($urandom_range(15)));
      end else if (r < 73) begin
        send(OP_TICK, prev, 1'($urandom_range(1)), 4'($urandom_range(15)));
      end else if (r < 80) begin
        send(OP_TICK, rand_minute(), 1'($urandom_range(1)), 4'($urandom_range(15)));
      end else if (r < 92) begin
        send(OP_READ, rand_minute(), 1'($urandom_range(1)), 4'($urandom_range(15)));
      end else if (r < 94) begin
        send(OP_CLR_LOG, rand_minute(), 1'($urandom_range(1)), 4'($urandom_range(15)));
      end else if (r < 96) begin
        send(rand_spare_op(), rand_minute(), 1'($urandom_range(1)), 4'($urandom_range(15)));
      end else begin
        send(OP_ADD, rand_minute(), 1'($urandom_range(1)), 4'($urandom_range(15)));
      end
    end
  endtask

  task automatic run_phase(int src, int snk, int n_items);
    int target;
    src_idle   = src;
    sink_stall = snk;
    target = sent + n_items;
    while (sent < target) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(15, 5)) noise_item();
      end else begin
        schedule_run();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(OP_TICK, 11'd0, 1'b0, 4'd0);
    send(OP_READ, 11'd0, 1'b0, 4'd0);
    send(OP_ADD, 11'd0, 1'b1, 4'd0);
    send(OP_ADD, 11'd0, 1'b1, 4'd15);
    send(OP_ADD, 11'd2047, 1'b0, 4'd0);
    send(OP_ADD, 11'd1439, 1'b1, 4'd0);
    send(OP_ADD, 11'd0, 1'b0, 4'd0);
    send(OP_TICK, 11'd0, 1'b0, 4'd0);
    send(OP_TICK, 11'd0, 1'b0, 4'd0);
    send(OP_TICK, 11'd2047, 1'b1, 4'd15);
    send(OP_TICK, 11'd1439, 1'b0, 4'd0);
    send(OP_TICK, 11'd0, 1'b0, 4'd0);
    send(OP_TICK, 11'd0, 1'b0, 4'd0);
    send(OP_READ, 11'd0, 1'b0, 4'd15);
    send(OP_READ, 11'd0, 1'b0, 4'd2);
    send(OP_READ, 11'd2047, 1'b1, 4'd3);
    send(OP_CLR_LOG, 11'd0, 1'b0, 4'd0);
    send(OP_READ, 11'd0, 1'b0, 4'd0);
    send(OP_NOP5, 11'd2047, 1'b1, 4'd15);
    send(OP_NOP7, 11'd0, 1'b0, 4'd0);
    send(OP_CLR_SCHED, 11'd0, 1'b0, 4'd0);
    send(OP_TICK, 11'd0, 1'b0, 4'd0);

    run_phase(0, 0, 180);
    run_phase(71, 0, 180);
    run_phase(0, 71, 180);
    run_phase(27, 27, 180);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
